@@ hdl/sfce_pkg.sv @@
`default_nettype none
package sfce_pkg;

  // Frame layout and CRC-16/MODBUS constants.
  localparam int unsigned FrameBytes = 17;
  localparam int unsigned IdxW       = 5;
  localparam int unsigned FifoDepth  = 2;

  localparam logic [7:0]  Hdr0       = 8'hAA;
  localparam logic [7:0]  Hdr1       = 8'h55;
  localparam logic [15:0] PayloadLen = 16'h0004;
  localparam logic [15:0] CrcInit    = 16'hFFFF;
  localparam logic [15:0] CrcPoly    = 16'hA001;

  // Byte positions inside one frame.
  localparam logic [IdxW-1:0] ByteHdr0    = 5'd0;
  localparam logic [IdxW-1:0] ByteHdr1    = 5'd1;
  localparam logic [IdxW-1:0] ByteType    = 5'd2;
  localparam logic [IdxW-1:0] ByteLenLo   = 5'd3;
  localparam logic [IdxW-1:0] ByteLenHi   = 5'd4;
  localparam logic [IdxW-1:0] ByteSeqLo   = 5'd5;
  localparam logic [IdxW-1:0] ByteSeqHi   = 5'd6;
  localparam logic [IdxW-1:0] ByteTs0     = 5'd7;
  localparam logic [IdxW-1:0] ByteTs1     = 5'd8;
  localparam logic [IdxW-1:0] ByteTs2     = 5'd9;
  localparam logic [IdxW-1:0] ByteTs3     = 5'd10;
  localparam logic [IdxW-1:0] ByteV1Lo    = 5'd11;
  localparam logic [IdxW-1:0] ByteV1Hi    = 5'd12;
  localparam logic [IdxW-1:0] ByteV2Lo    = 5'd13;
  localparam logic [IdxW-1:0] ByteV2Hi    = 5'd14;
  localparam logic [IdxW-1:0] ByteCrcLo   = 5'd15;
  localparam logic [IdxW-1:0] ByteCrcHi   = 5'd16;

  // One frame's worth of data, handed from the front to the back.
  typedef struct packed {
    logic [15:0]        seq;
    logic [15:0]        value_second;
    logic signed [15:0] value_first;
    logic [31:0]        timestamp_ms;
    logic [7:0]         frame_type;
  } frame_t;

  // Handshake between the front and the queue.
  typedef struct packed {
    logic   valid;
    frame_t data;
  } push_t;

  // Feed one byte into a reflected CRC-16 (poly 0xA001), bit by bit.
  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage
`default_nettype wire

@@ hdl/sfce_front.sv @@
`default_nettype none
module sfce_front (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  // tdata: frame_type[7:0], timestamp_ms[39:8], value_first[55:40], value_second[71:56]
  input  wire logic [71:0]     s_axis_tdata_i,
  output sfce_pkg::push_t      push_o,
  input  wire logic            push_ready_i
);
  import sfce_pkg::*;

  logic [15:0] seq_q, seq_d;
  logic        accept;

  assign s_axis_tready_o = push_ready_i;
  assign accept          = s_axis_tvalid_i & push_ready_i;

  // Unpack the transfer and tag it with the current sequence number.
  always_comb begin
    push_o.valid             = s_axis_tvalid_i;
    push_o.data.frame_type   = s_axis_tdata_i[7:0];
    push_o.data.timestamp_ms = s_axis_tdata_i[39:8];
    push_o.data.value_first  = s_axis_tdata_i[55:40];
    push_o.data.value_second = s_axis_tdata_i[71:56];
    push_o.data.seq          = seq_q;
  end

  // Sequence counter, wraps after 0xFFFF.
  assign seq_d = accept ? seq_q + 16'd1 : seq_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q <= '0;
    end else begin
      seq_q <= seq_d;
    end
  end

endmodule
`default_nettype wire

@@ hdl/sfce_fifo.sv @@
`default_nettype none
module sfce_fifo #(
  parameter int unsigned Depth = sfce_pkg::FifoDepth
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire sfce_pkg::push_t push_i,
  output logic                 push_ready_o,
  output logic                 pop_valid_o,
  output sfce_pkg::frame_t     pop_data_o,
  input  wire logic            pop_i
);
  import sfce_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);

  frame_t          mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign push_ready_o = (cnt_q != CntW'(Depth));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign do_push      = push_i.valid & push_ready_o;
  assign do_pop       = pop_i & pop_valid_o;

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Storage, no reset needed.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_i.data;
    end
  end

endmodule
`default_nettype wire

@@ hdl/sfce_back.sv @@
`default_nettype none
module sfce_back (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             pop_valid_i,
  input  wire sfce_pkg::frame_t pop_data_i,
  output logic                  pop_o,
  output logic                  m_axis_tvalid_o,
  input  wire logic             m_axis_tready_i,
  // tdata: out_byte[7:0]
  output logic [7:0]            m_axis_tdata_o,
  output logic                  m_axis_tlast_o
);
  import sfce_pkg::*;

  frame_t          frm_q, frm_d;
  logic            busy_q, busy_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic [15:0]     crc_q, crc_d;
  logic            ovalid_q, ovalid_d;
  logic [7:0]      obyte_q, obyte_d;
  logic            olast_q, olast_d;

  logic            advance, at_last;
  logic [7:0]      cur_byte;
  logic [15:0]     crc_in;

  assign advance = busy_q & (~ovalid_q | m_axis_tready_i);
  assign at_last = (idx_q == ByteCrcHi);
  assign pop_o   = pop_valid_i & (~busy_q | (advance & at_last));

  // Select the frame byte at the current position.
  always_comb begin
    case (idx_q)
      ByteHdr0:  cur_byte = Hdr0;
      ByteHdr1:  cur_byte = Hdr1;
      ByteType:  cur_byte = frm_q.frame_type;
      ByteLenLo: cur_byte = PayloadLen[7:0];
      ByteLenHi: cur_byte = PayloadLen[15:8];
      ByteSeqLo: cur_byte = frm_q.seq[7:0];
      ByteSeqHi: cur_byte = frm_q.seq[15:8];
      ByteTs0:   cur_byte = frm_q.timestamp_ms[7:0];
      ByteTs1:   cur_byte = frm_q.timestamp_ms[15:8];
      ByteTs2:   cur_byte = frm_q.timestamp_ms[23:16];
      ByteTs3:   cur_byte = frm_q.timestamp_ms[31:24];
      ByteV1Lo:  cur_byte = frm_q.value_first[7:0];
      ByteV1Hi:  cur_byte = frm_q.value_first[15:8];
      ByteV2Lo:  cur_byte = frm_q.value_second[7:0];
      ByteV2Hi:  cur_byte = frm_q.value_second[15:8];
      ByteCrcLo: cur_byte = crc_q[7:0];
      ByteCrcHi: cur_byte = crc_q[15:8];
      default:   cur_byte = 8'h00;
    endcase
  end

  // The CRC restarts at the first header byte of each frame.
  assign crc_in = (idx_q == ByteHdr0) ? CrcInit : crc_q;

  // Serializer: one byte per cycle into the output register while busy and not stalled.
  always_comb begin
    frm_d    = frm_q;
    busy_d   = busy_q;
    idx_d    = idx_q;
    crc_d    = crc_q;
    ovalid_d = ovalid_q & ~m_axis_tready_i;
    obyte_d  = obyte_q;
    olast_d  = olast_q;
    if (advance) begin
      ovalid_d = 1'b1;
      obyte_d  = cur_byte;
      olast_d  = at_last;
      if (idx_q < ByteCrcLo) begin
        crc_d = crc_feed(crc_in, cur_byte);
      end
      if (at_last) begin
        idx_d  = ByteHdr0;
        busy_d = 1'b0;
      end else begin
        idx_d = idx_q + IdxW'(1);
      end
    end
    if (pop_o) begin
      frm_d  = pop_data_i;
      busy_d = 1'b1;
      idx_d  = ByteHdr0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      idx_q    <= ByteHdr0;
      ovalid_q <= 1'b0;
    end else begin
      busy_q   <= busy_d;
      idx_q    <= idx_d;
      ovalid_q <= ovalid_d;
    end
  end

  // Payload registers, no reset needed.
  always_ff @(posedge clk_i) begin
    frm_q   <= frm_d;
    crc_q   <= crc_d;
    obyte_q <= obyte_d;
    olast_q <= olast_d;
  end

  assign m_axis_tvalid_o = ovalid_q;
  assign m_axis_tdata_o  = obyte_q;
  assign m_axis_tlast_o  = olast_q;

endmodule
`default_nettype wire

@@ hdl/sensor_frame_crc16_encoder_top.sv @@
// Path: queue, frame register, output register. Throughput: one output byte per
// cycle while a frame is loaded and the receiver is ready, set by the byte
// serializer; the two-entry queue lets input arrive while a frame is sent.
// Reset: asynchronous, active low; the sequence number restarts at zero and
// the queue and output are emptied.
`default_nettype none
module sensor_frame_crc16_encoder_top #(
  parameter int unsigned FifoDepth = sfce_pkg::FifoDepth
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  // tdata: frame_type[7:0], timestamp_ms[39:8], value_first[55:40], value_second[71:56]
  input  wire logic [71:0] s_axis_tdata_i,
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  // tdata: out_byte[7:0]
  output logic [7:0]       m_axis_tdata_o,
  // tlast: last_byte
  output logic             m_axis_tlast_o
);
  import sfce_pkg::*;

  push_t  push;
  logic   push_ready;
  logic   pop_valid, pop;
  frame_t pop_data;

  // Front: accepts items and assigns sequence numbers.
  sfce_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .push_o          (push),
    .push_ready_i    (push_ready)
  );

  // Queue decoupling the front from the serializer.
  sfce_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_ready_o (push_ready),
    .pop_valid_o  (pop_valid),
    .pop_data_o   (pop_data),
    .pop_i        (pop)
  );

  // Back: builds the frame and computes the CRC byte by byte.
  sfce_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .pop_valid_i     (pop_valid),
    .pop_data_i      (pop_data),
    .pop_o           (pop),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

endmodule
`default_nettype wire

@@ bench/testbench.sv @@
`default_nettype none
module testbench;
  import sfce_pkg::*;

  // A run of this many cycles without any transfer on either side is a hang.
  localparam int unsigned WatchdogLimit = 5000;
  localparam int unsigned MaxReports    = 10;
  localparam int unsigned TailCycles    = 20;
  localparam int unsigned HoldOffCycles = 300;

  // One sensor reading, laid out exactly as s_axis_tdata_i: frame_type in the low bits.
  typedef struct packed {
    logic [15:0]        value_second;
    logic signed [15:0] value_first;
    logic [31:0]        timestamp_ms;
    logic [7:0]         frame_type;
  } reading_t;

  // One frame byte as it should leave the block.
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } frame_byte_t;

  logic        clk_i           = 1'b0;
  logic        rst_ni          = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  // tdata: frame_type[7:0], timestamp_ms[39:8], value_first[55:40], value_second[71:56]
  logic [71:0] s_axis_tdata_i  = '0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  // tdata: out_byte[7:0]
  logic [7:0]  m_axis_tdata_o;
  // tlast: last_byte
  logic        m_axis_tlast_o;

  frame_byte_t pending_bytes[$];
  logic [15:0] next_seq         = '0;
  int unsigned src_idle_pct     = 0;
  int unsigned sink_idle_pct    = 0;
  int unsigned sink_hold_cycles = 0;
  int unsigned mismatches       = 0;
  int unsigned quiet_cycles     = 0;

  always #5 clk_i = ~clk_i;

  sensor_frame_crc16_encoder_top u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  // CRC-16/MODBUS over one byte: reflected shift, LSB first.
  function automatic logic [15:0] crc16_modbus_byte(input logic [15:0] crc,
                                                    input logic [7:0] b);
    logic [15:0] acc;
    acc = crc ^ {8'h00, b};
    repeat (8) begin
      acc = {1'b0, acc[15:1]} ^ (acc[0] ? CrcPoly : 16'h0000);
    end
    return acc;
  endfunction

  // Build the frame for one accepted reading and queue its bytes in wire order.
  function automatic void predict_frame(input reading_t r);
    logic [7:0]  frame [FrameBytes];
    logic [15:0] crc;
    int          i;
    frame[ByteHdr0]  = Hdr0;
    frame[ByteHdr1]  = Hdr1;
    frame[ByteType]  = r.frame_type;
    frame[ByteLenLo] = PayloadLen[7:0];
    frame[ByteLenHi] = PayloadLen[15:8];
    frame[ByteSeqLo] = next_seq[7:0];
    frame[ByteSeqHi] = next_seq[15:8];
    frame[ByteTs0]   = r.timestamp_ms[7:0];
    frame[ByteTs1]   = r.timestamp_ms[15:8];
    frame[ByteTs2]   = r.timestamp_ms[23:16];
    frame[ByteTs3]   = r.timestamp_ms[31:24];
    frame[ByteV1Lo]  = r.value_first[7:0];
    frame[ByteV1Hi]  = r.value_first[15:8];
    frame[ByteV2Lo]  = r.value_second[7:0];
    frame[ByteV2Hi]  = r.value_second[15:8];
    crc = CrcInit;
    for (i = 0; i < int'(ByteCrcLo); i++) begin
      crc = crc16_modbus_byte(crc, frame[i]);
    end
    frame[ByteCrcLo] = crc[7:0];
    frame[ByteCrcHi] = crc[15:8];
    for (i = 0; i < FrameBytes; i++) begin
      pending_bytes.push_back('{frame[i], (i == FrameBytes - 1)});
    end
    next_seq = next_seq + 16'd1;
  endfunction

  function automatic reading_t make_reading(input logic [7:0] frame_type,
                                            input logic [31:0] timestamp_ms,
                                            input logic signed [15:0] value_first,
                                            input logic [15:0] value_second);
    return '{value_second, value_first, timestamp_ms, frame_type};
  endfunction

  // Random reading; fields at times forced all zeros or ones; value_first min, max or -1.
  function automatic reading_t rand_reading();
    reading_t    r;
    logic [95:0] raw;
    raw = {$urandom, $urandom, $urandom};
    r   = raw[71:0];
    case ($urandom_range(7))
      0: r.frame_type = '0;
      1: r.frame_type = '1;
      default: ;
    endcase
    case ($urandom_range(7))
      0: r.timestamp_ms = '0;
      1: r.timestamp_ms = '1;
      default: ;
    endcase
    case ($urandom_range(7))
      0: r.value_first = 16'sh8000;
      1: r.value_first = 16'sh7FFF;
      2: r.value_first = '1;
      default: ;
    endcase
    case ($urandom_range(7))
      0: r.value_second = '0;
      1: r.value_second = '1;
      default: ;
    endcase
    return r;
  endfunction

  function automatic void report_mismatch(input string what, input logic [7:0] want,
                                          input logic [7:0] got);
    mismatches++;
    if (mismatches <= MaxReports) begin
      $display("Mismatch at %0t: %s expected %02h got %02h", $realtime, what, want, got);
    end
  endfunction

  // Offer one reading, with random idle cycles ahead of it, until it is taken.
  // tvalid stays high afterwards so back-to-back transfers need no extra edge.
  task automatic send_reading(input reading_t r);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= r;
    do @(posedge clk_i); while (!s_axis_tready_o);
    predict_frame(r);
  endtask

  // Stop offering input and wait until every queued frame byte has come out.
  task automatic wait_frames_done();
    s_axis_tvalid_i <= 1'b0;
    do @(posedge clk_i); while (pending_bytes.size() != 0);
  endtask

  // Field extremes, alternating bit patterns and both common frame types.
  task automatic test_field_extremes();
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    send_reading(make_reading(8'h00, 32'h0000_0000, 16'sh0000, 16'h0000));
    send_reading(make_reading(8'hFF, 32'hFFFF_FFFF, 16'shFFFF, 16'hFFFF));
    send_reading(make_reading(8'h01, 32'h1234_5678, 16'sh7FFF, 16'h0001));
    send_reading(make_reading(8'hA1, 32'h8000_0000, 16'sh8000, 16'h8000));
    send_reading(make_reading(8'h55, 32'hAAAA_AAAA, 16'sh5555, 16'hAAAA));
    send_reading(make_reading(8'hAA, 32'h5555_5555, 16'shAAAA, 16'h5555));
    send_reading(make_reading(8'h80, 32'h0000_0001, 16'sh0001, 16'h7FFF));
    send_reading(make_reading(8'h7F, 32'h7FFF_FFFF, 16'shFFFE, 16'h0000));
    send_reading(make_reading(8'h01, 32'h0000_FFFF, 16'sh8001, 16'hFF00));
    send_reading(make_reading(8'hA1, 32'hFFFF_0000, 16'sh00FF, 16'h00FF));
    wait_frames_done();
  endtask

  // The receiver holds off for a long stretch while input keeps coming, so the
  // internal queue fills and input ready has to drop.
  task automatic test_backpressure();
    int n;
    src_idle_pct     = 0;
    sink_idle_pct    = 0;
    sink_hold_cycles = HoldOffCycles;
    for (n = 0; n < 6; n++) begin
      send_reading(rand_reading());
    end
    wait_frames_done();
  endtask

  task automatic test_random_traffic(input int unsigned count, input int unsigned src_pct,
                                     input int unsigned sink_pct);
    int unsigned n;
    src_idle_pct  = src_pct;
    sink_idle_pct = sink_pct;
    for (n = 0; n < count; n++) begin
      send_reading(rand_reading());
    end
    wait_frames_done();
  endtask

  // Receiver ready: a requested hold-off first, otherwise random stalls.
  always @(posedge clk_i) begin
    if (sink_hold_cycles != 0) begin
      m_axis_tready_i  <= 1'b0;
      sink_hold_cycles <= sink_hold_cycles - 1;
    end else begin
      m_axis_tready_i <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  // Compare every output transfer with the oldest predicted frame byte.
  always @(posedge clk_i) begin : byte_checker
    frame_byte_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (pending_bytes.size() == 0) begin
        report_mismatch("unexpected byte", 8'h00, m_axis_tdata_o);
      end else begin
        want = pending_bytes.pop_front();
        if (m_axis_tdata_o !== want.data) begin
          report_mismatch("out_byte", want.data, m_axis_tdata_o);
        end
        if (m_axis_tlast_o !== want.last) begin
          report_mismatch("last_byte", {7'd0, want.last}, {7'd0, m_axis_tlast_o});
        end
      end
    end
  end

  // Hang detection: count cycles in which no transfer happens on either side.
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid_i && s_axis_tready_o) ||
        (m_axis_tvalid_o && m_axis_tready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_field_extremes();
    test_backpressure();
    test_random_traffic(145, 27, 50);
    test_random_traffic(145, 50, 27);
    test_random_traffic(145, 0, 0);

    // Anything that still comes out now has no frame behind it.
    repeat (TailCycles) @(posedge clk_i);
    if (mismatches == 0 && pending_bytes.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire
